// File: design/c2pt_pkg.sv
// ----------------------------------------------------------------------------
// c2pt_pkg: shared constants for the rectangular-to-polar converter
// Angle table for the vectoring CORDIC, fixed-point scale factors and the
// phase rounding and saturation limits.
// ----------------------------------------------------------------------------
package c2pt_pkg;

  // angle accumulator width, Q30 radians with headroom for pi plus the rotations
  localparam int ZW = 35;

  // input pre-scale for the CORDIC datapath, as a left shift
  localparam int PRESCALE_SHIFT = 20;

  // Q30 to Q13 rounding
  localparam int ROUND_SHIFT = 17;
  localparam logic [ZW-1:0] ROUND_HALF = ZW'(65536);

  // phase limit, pi in Q13
  localparam logic [15:0] PHASE_MAX = 16'd25736;

  // pi in Q30
  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

  // atan(2^-i) in Q30, i = 0..31
  localparam logic [31:0] ATAN_Q30 [0:31] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,
    32'd64,        32'd32,        32'd16,        32'd8,
    32'd4,         32'd2,         32'd1,         32'd0
  };

endpackage

// File: design/cartesian_to_polar_thresholded.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_thresholded: pipelined rectangular-to-polar converter
// Amplitude by a bit-per-stage integer square root, phase by a vectoring
// CORDIC, phase forced to zero below a programmable amplitude threshold.
// ----------------------------------------------------------------------------
// The block takes one (cos, sin) transaction per clock while in_stall is
// low and returns one (amplitude, phase) transaction per input, in order.
// Amplitude is the exact floor(sqrt(c*c + s*s)), saturated to 16 bits; phase
// is atan2(s, c) in Q3.13 radians, zero for the zero vector and zero whenever
// the amplitude is below cfg amp_threshold. The square-root pipeline spends
// one stage per root bit (IN_WIDTH stages) and the CORDIC one stage per
// rotation (CORDIC_STAGES stages), and the shorter branch is delayed to match.
// The output register has a one-entry skid stage behind it, so in_stall only
// rises after the output has been stalled while another result was arriving;
// it is a registered signal. Write the threshold only while no transaction is
// in flight.
module cartesian_to_polar_thresholded #(
  parameter int IN_WIDTH      = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [15:0]                cfg_wr_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [IN_WIDTH-1:0] in_cos_part,
  input  logic signed [IN_WIDTH-1:0] in_sin_part,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                out_amplitude,
  output logic signed [15:0]         out_phase
);

  localparam int W     = IN_WIDTH;
  localparam int N     = CORDIC_STAGES;
  localparam int ZW    = c2pt_pkg::ZW;
  localparam int XW    = W + c2pt_pkg::PRESCALE_SHIFT + 3;
  localparam int RW    = W + 2;
  localparam int LAT_A = W + 3;
  localparam int LAT_P = N + 3;
  localparam int LAT   = (LAT_A > LAT_P) ? LAT_A : LAT_P;
  localparam int DA    = LAT - LAT_A;
  localparam int DP    = LAT - LAT_P;
  localparam int CW    = (W > 16) ? W : 16;
  localparam int QW    = ZW - c2pt_pkg::ROUND_SHIFT;

  // control
  logic           en;
  logic [LAT:0]   v_r;
  logic [15:0]    thr_r;
  logic           skid_v_r;
  logic           out_valid_r;
  logic           up_valid;
  logic           out_take;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // whole pipeline advances unless the skid stage is holding a result
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-1:0], in_valid};
    end
  end

  // stage 0: input capture
  logic signed [W-1:0] c_r, s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= in_cos_part;
      s_r <= in_sin_part;
    end
  end

  // ---------------- amplitude branch ----------------

  // stage 1: magnitudes
  logic [W-1:0]   cm_r, sm_r;
  // stage 2: squares
  logic [2*W-1:0] csq_r, ssq_r;
  // stage 3 and the root stages: remainder, partial root, radicand
  logic [RW-1:0]  rem_r [0:W];
  logic [W-1:0]   q_r   [0:W];
  logic [2*W-1:0] n_r   [0:W];

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r     <= c_r[W-1] ? (~c_r + W'(1)) : c_r;
      sm_r     <= s_r[W-1] ? (~s_r + W'(1)) : s_r;
      csq_r    <= (2*W)'(cm_r) * (2*W)'(cm_r);
      ssq_r    <= (2*W)'(sm_r) * (2*W)'(sm_r);
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      n_r[0]   <= csq_r + ssq_r;
    end
  end

  // one root bit per stage, most significant first
  for (genvar gk = 1; gk <= W; gk++) begin : g_root
    logic [RW-1:0] rem_t;
    logic [RW-1:0] trial;
    logic          fits;

    assign rem_t = {rem_r[gk-1][W-1:0], n_r[gk-1][2*W-1:2*W-2]};
    assign trial = {q_r[gk-1], 2'b01};
    assign fits  = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gk] <= fits ? (rem_t - trial) : rem_t;
        q_r[gk]   <= {q_r[gk-1][W-2:0], fits};
        n_r[gk]   <= {n_r[gk-1][2*W-3:0], 2'b00};
      end
    end
  end

  // delay to match the phase branch
  logic [W-1:0] amp_d [0:DA];

  assign amp_d[0] = q_r[W];

  for (genvar gd = 1; gd <= DA; gd++) begin : g_amp_dly
    always_ff @(posedge clk) begin
      if (en) begin
        amp_d[gd] <= amp_d[gd-1];
      end
    end
  end

  // ---------------- phase branch ----------------

  logic signed [XW-1:0] x_r    [0:N];
  logic signed [XW-1:0] y_r    [0:N];
  logic signed [ZW-1:0] z_r    [0:N];
  logic                 zero_r [0:N];

  // stage 1: fold the left half-plane onto the right, pre-scale
  logic signed [XW-1:0] c_ext, s_ext;

  assign c_ext = XW'(c_r);
  assign s_ext = XW'(s_r);

  always_ff @(posedge clk) begin
    if (en) begin
      if (c_r[W-1]) begin
        x_r[0] <= (-c_ext) <<< c2pt_pkg::PRESCALE_SHIFT;
        y_r[0] <= (-s_ext) <<< c2pt_pkg::PRESCALE_SHIFT;
        z_r[0] <= s_r[W-1] ? -c2pt_pkg::PI_Q30 : c2pt_pkg::PI_Q30;
      end else begin
        x_r[0] <= c_ext <<< c2pt_pkg::PRESCALE_SHIFT;
        y_r[0] <= s_ext <<< c2pt_pkg::PRESCALE_SHIFT;
        z_r[0] <= '0;
      end
      zero_r[0] <= (c_r == '0) && (s_r == '0);
    end
  end

  // one micro-rotation per stage, driving y toward zero
  for (genvar gi = 1; gi <= N; gi++) begin : g_rot
    localparam int SH = gi - 1;
    logic signed [XW-1:0] xsh, ysh;
    logic signed [ZW-1:0] ang;

    assign xsh = x_r[gi-1] >>> SH;
    assign ysh = y_r[gi-1] >>> SH;
    assign ang = $signed({{(ZW-32){1'b0}}, c2pt_pkg::ATAN_Q30[SH]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[gi-1][XW-1]) begin
          x_r[gi] <= x_r[gi-1] + ysh;
          y_r[gi] <= y_r[gi-1] - xsh;
          z_r[gi] <= z_r[gi-1] + ang;
        end else begin
          x_r[gi] <= x_r[gi-1] - ysh;
          y_r[gi] <= y_r[gi-1] + xsh;
          z_r[gi] <= z_r[gi-1] - ang;
        end
        zero_r[gi] <= zero_r[gi-1];
      end
    end
  end

  // rounding stage 1: magnitude plus half, sign kept aside
  logic [ZW-1:0] zmag_r;
  logic          zneg_r;
  logic          zzero_r;
  logic [ZW-1:0] zabs;

  assign zabs = z_r[N][ZW-1] ? (~z_r[N] + ZW'(1)) : z_r[N];

  always_ff @(posedge clk) begin
    if (en) begin
      zmag_r  <= zabs + c2pt_pkg::ROUND_HALF;
      zneg_r  <= z_r[N][ZW-1];
      zzero_r <= zero_r[N];
    end
  end

  // rounding stage 2: to Q13, saturate, restore sign
  logic [QW-1:0]      zq;
  logic [15:0]        pmag;
  logic signed [15:0] ph_r;

  assign zq   = zmag_r[ZW-1:c2pt_pkg::ROUND_SHIFT];
  assign pmag = (zq > QW'(c2pt_pkg::PHASE_MAX)) ? c2pt_pkg::PHASE_MAX : zq[15:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zzero_r) begin
        ph_r <= '0;
      end else begin
        ph_r <= zneg_r ? -$signed(pmag) : $signed(pmag);
      end
    end
  end

  // delay to match the amplitude branch
  logic signed [15:0] ph_d [0:DP];

  assign ph_d[0] = ph_r;

  for (genvar gd = 1; gd <= DP; gd++) begin : g_ph_dly
    always_ff @(posedge clk) begin
      if (en) begin
        ph_d[gd] <= ph_d[gd-1];
      end
    end
  end

  // ---------------- threshold and output ----------------

  logic [CW-1:0]      amp_ext;
  logic [15:0]        res_amp;
  logic signed [15:0] res_ph;

  assign amp_ext = CW'(amp_d[DA]);
  assign res_amp = (amp_ext > CW'(16'hFFFF)) ? 16'hFFFF : amp_ext[15:0];
  assign res_ph  = (amp_ext < CW'(thr_r)) ? 16'sd0 : ph_d[DP];

  // output register with a one-entry skid stage behind it
  logic [15:0]        out_amp_r, skid_amp_r;
  logic signed [15:0] out_ph_r, skid_ph_r;

  assign up_valid = v_r[LAT] && en;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take || !out_valid_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end
    end else if (up_valid) begin
      if (out_valid_r && !out_take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take || !out_valid_r) begin
        out_amp_r <= skid_amp_r;
        out_ph_r  <= skid_ph_r;
      end
    end else if (up_valid) begin
      if (out_valid_r && !out_take) begin
        skid_amp_r <= res_amp;
        skid_ph_r  <= res_ph;
      end else begin
        out_amp_r <= res_amp;
        out_ph_r  <= res_ph;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_amplitude = out_amp_r;
  assign out_phase     = out_ph_r;

  // ---------------- assertions ----------------

  // the skid stage only holds a result behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // skid fills only when a result arrived at a stalled, full output
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall && v_r[LAT]))
    else $error("skid stage filled without a stalled output");

  // a frozen pipeline keeps its valid bits
  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(v_r))
    else $error("pipeline moved while stalled");

  // phase stays within plus or minus pi
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ph_r <= 16'sd25736 && out_ph_r >= -16'sd25736))
    else $error("phase out of range");

endmodule

// File: verif/tb_cartesian_to_polar_thresholded.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_polar_thresholded: self-checking bench for the converter
// Drives (cos, sin) transactions with random idles and output stalls, predicts
// amplitude and thresholded CORDIC phase in a local model and compares every
// result in order. A directed table comes first, then random phases at
// several thresholds.
// ----------------------------------------------------------------------------
module tb_cartesian_to_polar_thresholded;

  // pipeline depth allowance, used in the final wait
  localparam int PIPE_LATENCY   = 20;
  localparam int ROTATIONS      = 16;
  localparam int PHASE_LIMIT    = 25736;
  localparam int THRESH_TOP     = 46341;
  localparam int ITEMS_PER_RUN  = 300;
  localparam int NUM_RUNS       = 6;
  localparam longint ANGLE_PI   = 64'sd3373259426;

  // atan(2^-i) in Q30 radians
  localparam longint ATAN_STEP [0:ROTATIONS-1] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768
  };

  typedef struct packed {
    logic [15:0]        amplitude;
    logic signed [15:0] phase;
  } polar_t;

  // one directed row: threshold in force, input, and an optional fixed answer
  typedef struct packed {
    logic [15:0]        thr;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
    bit                 fixed;
    logic [15:0]        amp;
    logic signed [15:0] ph;
  } voxel_case_t;

  localparam int NUM_CASES = 25;
  voxel_case_t voxel_cases [0:NUM_CASES-1] = '{
    '{16'd0,     16'sd0,      16'sd0,      1'b1, 16'd0,     16'sd0},
    '{16'd0,     16'sd1,      16'sd0,      1'b1, 16'd1,     16'sd0},
    '{16'd0,     -16'sd1,     16'sd0,      1'b1, 16'd1,     16'sd25736},
    '{16'd0,     16'sd32767,  16'sd0,      1'b1, 16'd32767, 16'sd0},
    '{16'd0,     -16'sd32768, 16'sd0,      1'b1, 16'd32768, 16'sd25736},
    '{16'd0,     16'sd0,      16'sd32767,  1'b0, 16'd0,     16'sd0},
    '{16'd0,     16'sd0,      -16'sd32768, 1'b0, 16'd0,     16'sd0},
    '{16'd0,     -16'sd32768, -16'sd32768, 1'b0, 16'd0,     16'sd0},
    '{16'd0,     16'sd32767,  16'sd32767,  1'b0, 16'd0,     16'sd0},
    '{16'd0,     -16'sd32768, 16'sd32767,  1'b0, 16'd0,     16'sd0},
    '{16'd0,     16'sd32767,  -16'sd32768, 1'b0, 16'd0,     16'sd0},
    '{16'd0,     -16'sd32768, -16'sd1,     1'b0, 16'd0,     16'sd0},
    '{16'd0,     -16'sd1,     -16'sd1,     1'b0, 16'd0,     16'sd0},
    '{16'd0,     -16'sd1,     16'sd1,      1'b0, 16'd0,     16'sd0},
    '{16'd0,     16'sd3,      16'sd4,      1'b0, 16'd0,     16'sd0},
    '{16'd0,     -16'sd5,     -16'sd12,    1'b0, 16'd0,     16'sd0},
    '{16'd0,     16'sd21845,  -16'sd21846, 1'b0, 16'd0,     16'sd0},
    '{16'd0,     -16'sd21846, 16'sd21845,  1'b0, 16'd0,     16'sd0},
    '{16'd5,     16'sd3,      16'sd4,      1'b0, 16'd0,     16'sd0},
    '{16'd5,     16'sd3,      16'sd3,      1'b1, 16'd4,     16'sd0},
    '{16'd5,     16'sd0,      16'sd0,      1'b1, 16'd0,     16'sd0},
    '{16'd5,     -16'sd4,     -16'sd3,     1'b0, 16'd0,     16'sd0},
    '{16'd46341, -16'sd32768, -16'sd32768, 1'b1, 16'd46340, 16'sd0},
    '{16'd46341, 16'sd32767,  -16'sd1,     1'b1, 16'd32767, 16'sd0},
    '{16'd46341, -16'sd32768, 16'sd1,      1'b1, 16'd32768, 16'sd0}
  };

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_cos_part;
  logic signed [15:0] in_sin_part;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_amplitude;
  logic signed [15:0] out_phase;

  polar_t      pending_polar [$];
  logic [15:0] amp_thr;
  int          mismatch_count = 0;
  int          stall_run = 0;
  bit          no_gaps;

  cartesian_to_polar_thresholded DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cos_part   (in_cos_part),
    .in_sin_part   (in_sin_part),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_amplitude (out_amplitude),
    .out_phase     (out_phase)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // exact floor square root, two bits per step
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // vectoring cordic in Q30, rounded half away from zero to Q13
  function automatic logic signed [15:0] cordic_angle(input longint c, input longint s);
    longint x, y, z, dx, dy, mag, r;
    z = 0;
    if (c == 0 && s == 0) return 16'sd0;
    if (c < 0) begin
      x = -c * (64'sd1 << 20);
      y = -s * (64'sd1 << 20);
      z = (s >= 0) ? ANGLE_PI : -ANGLE_PI;
    end else begin
      x = c * (64'sd1 << 20);
      y = s * (64'sd1 << 20);
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_STEP[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_STEP[i];
      end
    end
    mag = (z < 0) ? -z : z;
    r = (mag + 65536) >>> 17;
    if (r > PHASE_LIMIT) r = PHASE_LIMIT;
    return (z < 0) ? 16'(-r) : 16'(r);
  endfunction

  // amplitude plus phase, phase zeroed below the threshold
  function automatic polar_t predict_polar(input logic signed [15:0] c,
                                           input logic signed [15:0] s);
    polar_t res;
    longint cl, sl;
    longint unsigned amp;
    cl = c;
    sl = s;
    amp = root_floor(longint'(cl * cl + sl * sl));
    res.amplitude = (amp > 64'd65535) ? 16'hFFFF : amp[15:0];
    res.phase = (amp >= amp_thr) ? cordic_angle(cl, sl) : 16'sd0;
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transaction on the input channel, with its expected result queued
  task automatic send_voxel(input logic signed [15:0] c, input logic signed [15:0] s,
                            input polar_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cos_part <= c;
    in_sin_part <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_polar.push_back(want);
  endtask

  // hold the input until every queued result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
  endtask

  // threshold write, only with the pipeline empty
  task automatic set_threshold(input logic [15:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    amp_thr = value;
  endtask

  // random voxel, biased toward extremes, axes, diagonals and the threshold circle
  task automatic random_voxel(output logic signed [15:0] c, output logic signed [15:0] s);
    int kind;
    longint a, b, t;
    logic signed [15:0] corners [0:5];
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    kind = $urandom_range(0, 9);
    c = 16'($urandom());
    s = 16'($urandom());
    case (kind)
      4, 5: begin
        c = 16'($urandom_range(0, 64) - 32);
        s = 16'($urandom_range(0, 64) - 32);
      end
      6: begin
        if ($urandom_range(0, 1)) c = '0;
        else s = '0;
      end
      7: begin
        c = corners[$urandom_range(0, 5)];
        s = corners[$urandom_range(0, 5)];
      end
      8: begin
        s = $urandom_range(0, 1) ? c : -c;
        s = 16'(s + $urandom_range(0, 4) - 2);
      end
      9: begin
        t = amp_thr;
        a = $urandom_range(0, (t > 32767) ? 32767 : t);
        b = root_floor(t * t - a * a) + $urandom_range(0, 2) - 1;
        if (b < 0) b = 0;
        if (b > 32767) b = 32767;
        c = $urandom_range(0, 1) ? 16'(a) : 16'(-a);
        s = $urandom_range(0, 1) ? 16'(b) : 16'(-b);
      end
      default: ;
    endcase
  endtask

  // result channel: compare against the oldest expectation, then pick the next stall
  always @(posedge clk) begin : result_check
    polar_t want;
    int r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_polar.size() == 0) begin
        $error("unexpected result transaction: amplitude %0d phase %0d",
               out_amplitude, out_phase);
        mismatch_count++;
      end else begin
        want = pending_polar.pop_front();
        if (out_amplitude !== want.amplitude) begin
          $error("amplitude: expected %0d, actual %0d", want.amplitude, out_amplitude);
          mismatch_count++;
        end
        if (out_phase !== want.phase) begin
          $error("phase: expected %0d, actual %0d", want.phase, out_phase);
          mismatch_count++;
        end
      end
    end
    r = $urandom_range(0, 99);
    if (no_gaps) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (r < 15) begin
      out_stall <= 1'b1;
      stall_run = (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // stimulus
  initial begin
    logic signed [15:0] c, s;
    polar_t want;
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_cos_part    = '0;
    in_sin_part    = '0;
    amp_thr        = '0;
    no_gaps        = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int k = 0; k < NUM_CASES; k++) begin
      if (voxel_cases[k].thr != amp_thr) set_threshold(voxel_cases[k].thr);
      if (voxel_cases[k].fixed) begin
        want.amplitude = voxel_cases[k].amp;
        want.phase     = voxel_cases[k].ph;
      end else begin
        want = predict_polar(voxel_cases[k].cos_v, voxel_cases[k].sin_v);
      end
      send_voxel(voxel_cases[k].cos_v, voxel_cases[k].sin_v, want);
    end

    // random runs, each at its own threshold
    for (int run = 0; run < NUM_RUNS; run++) begin
      case (run)
        0: set_threshold(16'($urandom_range(0, THRESH_TOP)));
        1: set_threshold(16'd0);
        2: set_threshold(16'(THRESH_TOP));
        3: set_threshold(16'($urandom_range(1, 2000)));
        4: set_threshold(16'($urandom_range(20000, 40000)));
        default: set_threshold(16'($urandom_range(0, 100)));
      endcase
      no_gaps = (run == 1);
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        // in the first run the sender holds off once mid-run until the pipeline is empty
        if (run == 0 && n == ITEMS_PER_RUN / 2) drain_results();
        random_voxel(c, s);
        send_voxel(c, s, predict_polar(c, s));
      end
    end
    no_gaps = 1'b0;

    drain_results();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_polar.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
